// ----- sv/ppfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ppfr_pkg
// Shared types and constants for the preamble/postamble frame receiver.
// ----------------------------------------------------------------------------
package ppfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MARK_W     = 16;
  localparam int unsigned MARK_BYTES = 2;
  localparam int unsigned BYTE_IDX_W = 6;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSTAMBLE = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_SEND,
    S_ERR
  } ppfr_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic byte_fire;   // input byte transferred this cycle
    logic emit_start;  // rewind the read pointer
    logic rd_en;       // issue a frame store read
    logic rd_step;     // advance the read pointer
    logic show_err;    // output carries the error result
  } ppfr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_done;  // current byte completes the postamble
    logic len_ok;      // length field equals frame length
    logic rd_last;     // read pointer at the final frame byte
  } ppfr_sts_t;

endpackage

// ----- sv/ppfr_ram.sv -----
// ----------------------------------------------------------------------------
// ppfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ppfr_dp.sv -----
// ----------------------------------------------------------------------------
// ppfr_dp
// Datapath: marker matching, frame store, length field and result fields.
// ----------------------------------------------------------------------------
module ppfr_dp #(
  parameter int unsigned FIELD_BYTES = 2,
  parameter int unsigned FRAME_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppfr_pkg::MARK_W-1:0]         cfg_data_i,
  input  logic [ppfr_pkg::BYTE_W-1:0]         rx_byte_i,
  input  ppfr_pkg::ppfr_cmd_t                 cmd_i,
  output ppfr_pkg::ppfr_sts_t                 sts_o,
  output logic [ppfr_pkg::BYTE_W-1:0]         frame_byte_o,
  output logic [ppfr_pkg::BYTE_IDX_W-1:0]     byte_index_o,
  output logic                                last_o,
  output logic                                status_o
);
  import ppfr_pkg::*;

  localparam int unsigned AW       = $clog2(FRAME_DEPTH);
  localparam int unsigned FIELD_W  = FIELD_BYTES * BYTE_W;
  localparam logic [AW-1:0] WI_MAX = AW'(FRAME_DEPTH - 1);

  logic [MARK_W-1:0] pre_word_q, post_word_q;
  logic              collecting_q, collecting_d;
  logic              pre_cnt_q, pre_cnt_d;
  logic              post_cnt_q, post_cnt_d;
  logic [AW-1:0]     wi_q, wi_d;
  logic [AW-1:0]     rd_idx_q;
  logic [BYTE_W-1:0] field_q [FIELD_BYTES];

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     wi_inc;
  logic [BYTE_W-1:0] pre_byte, post_byte;
  logic              post_hit;
  logic [FIELD_W-1:0] len_field;
  logic [BYTE_W-1:0] rdata;

  assign pre_byte  = pre_cnt_q  ? pre_word_q[15:8]  : pre_word_q[7:0];
  assign post_byte = post_cnt_q ? post_word_q[15:8] : post_word_q[7:0];
  assign wi_inc    = (wi_q < WI_MAX) ? wi_q + AW'(1) : wi_q;
  assign post_hit  = (rx_byte_i == post_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_word_q  <= '0;
      post_word_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PREAMBLE:  pre_word_q  <= cfg_data_i;
        CFG_POSTAMBLE: post_word_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    collecting_d = collecting_q;
    pre_cnt_d    = pre_cnt_q;
    post_cnt_d   = post_cnt_q;
    wi_d         = wi_q;
    we           = 1'b0;
    waddr        = wi_inc;
    if (cmd_i.byte_fire) begin
      if (!collecting_q) begin
        waddr = AW'(pre_cnt_q);
        if (rx_byte_i == pre_byte) begin
          we = 1'b1;
          if (pre_cnt_q) begin
            pre_cnt_d    = 1'b0;
            wi_d         = AW'(MARK_BYTES - 1);
            collecting_d = 1'b1;
          end else begin
            pre_cnt_d = 1'b1;
          end
        end else begin
          pre_cnt_d = 1'b0;
        end
      end else begin
        we   = 1'b1;
        wi_d = wi_inc;
        if (post_hit && post_cnt_q) begin
          post_cnt_d   = 1'b0;
          collecting_d = 1'b0;
        end else begin
          post_cnt_d = post_hit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      pre_cnt_q    <= 1'b0;
      post_cnt_q   <= 1'b0;
      wi_q         <= '0;
      rd_idx_q     <= '0;
    end else begin
      collecting_q <= collecting_d;
      pre_cnt_q    <= pre_cnt_d;
      post_cnt_q   <= post_cnt_d;
      wi_q         <= wi_d;
      if (cmd_i.emit_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_step) begin
        rd_idx_q <= rd_idx_q + AW'(1);
      end
    end
  end

  // Shadow copy of the length field slots, kept in step with the store
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FIELD_BYTES; i++) begin
      if (we && waddr == AW'(MARK_BYTES + i)) begin
        field_q[i] <= rx_byte_i;
      end
    end
  end

  always_comb begin
    len_field = '0;
    for (int i = 0; i < FIELD_BYTES; i++) begin
      len_field[i*BYTE_W +: BYTE_W] = field_q[i];
    end
  end

  ppfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  assign sts_o.frame_done = collecting_q && post_hit && post_cnt_q;
  assign sts_o.len_ok     = (LEN_W'(len_field) == LEN_W'(wi_q) + LEN_W'(1));
  assign sts_o.rd_last    = (rd_idx_q == wi_q);

  assign frame_byte_o = cmd_i.show_err ? '0 : rdata;
  assign byte_index_o = cmd_i.show_err ? '0 : BYTE_IDX_W'(rd_idx_q);
  assign last_o       = cmd_i.show_err | (rd_idx_q == wi_q);
  assign status_o     = cmd_i.show_err;

endmodule

// ----- sv/ppfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppfr_ctrl
// Controller: byte intake, length check and frame readout sequencing.
// ----------------------------------------------------------------------------
module ppfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ppfr_pkg::ppfr_sts_t sts_i,
  output ppfr_pkg::ppfr_cmd_t cmd_o
);
  import ppfr_pkg::*;

  ppfr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.byte_fire = in_valid_i;
        if (in_valid_i && sts_i.frame_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.emit_start = 1'b1;
        state_d = sts_i.len_ok ? S_READ : S_ERR;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SEND;
      end
      S_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.rd_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_step = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      S_ERR: begin
        out_valid_o    = 1'b1;
        cmd_o.show_err = 1'b1;
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/preamble_postamble_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// preamble_postamble_frame_receiver
// Byte stream deframer with preamble/postamble detection and length check.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one byte per
// cycle while no frame is being reported. Each byte either advances the
// preamble match or, once inside a frame, goes into the frame store.
// When the postamble completes, the check state compares the length field (the
// FIELD_BYTES bytes after the preamble, little-endian) against the frame
// length. A good frame is then read out of the store on the output channel
// (out_valid_o / out_stall_i), one byte at a time (store read, then
// output), last_o on the final byte. A bad frame gives one result with
// status_o set. Input is stalled from the closing postamble byte until the
// last result transfers; out_stall_i simply holds the current result.
// The config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0
// is the preamble, 1 the postamble, others ignored. Write it only while idle.
// Reset clears the matchers, markers and controller; the frame store is
// not cleared.
// ----------------------------------------------------------------------------
module preamble_postamble_frame_receiver #(
  parameter int unsigned FIELD_BYTES = 2,
  parameter int unsigned FRAME_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ppfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppfr_pkg::MARK_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ppfr_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ppfr_pkg::BYTE_W-1:0]     frame_byte_o,
  output logic [ppfr_pkg::BYTE_IDX_W-1:0] byte_index_o,
  output logic                            last_o,
  output logic                            status_o
);
  import ppfr_pkg::*;

  ppfr_cmd_t cmd;
  ppfr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ppfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppfr_dp #(
    .FIELD_BYTES (FIELD_BYTES),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule
